// ===== rtl/pctc_pkg.sv =====
// Package for the prefix code trie checker.
// Holds the opcodes and the command type passed from the front end to the trie walker.
// No dependencies.
package pctc_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_END    = 1'b1;

	localparam int BITS_W = 16;
	localparam int LEN_W  = 5;

	typedef struct packed {
		logic              op;
		logic [BITS_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

// ===== rtl/pctc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the trie node table. No dependencies.
module pctc_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pctc_front.sv =====
// Front end of the prefix code trie checker: accepts input items, saturates the
// codeword length and queues commands in a two-entry queue. Depends on pctc_pkg.
module pctc_front
	import pctc_pkg::*;
#(
	parameter int MAX_CODE_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic             push;
	logic             pop;
	logic [LEN_W-1:0] len_in;
	logic [LEN_W-1:0] len_sat;
	cmd_t             cmd_in;

	assign len_in  = s_tdata[20:16];
	// Lengths beyond the supported maximum are clipped to it.
	assign len_sat = (32'(len_in) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len_in;

	always_comb begin
		cmd_in      = '0;
		cmd_in.op   = s_tuser;
		cmd_in.bits = s_tdata[15:0];
		cmd_in.len  = len_sat;
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/pctc_walk.sv =====
// Back end of the prefix code trie checker: walks and extends the trie in the node
// table one code bit per cycle and holds the verdict in an output register.
// Depends on pctc_pkg and pctc_ram.
module pctc_walk
	import pctc_pkg::*;
#(
	parameter int NODES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	localparam int IW = $clog2(NODES);
	localparam int EW = 2 * IW + 1;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EVAL = 2'b10
	} bstate_t;

	bstate_t           state_q;
	logic [IW-1:0]     node_q;
	logic              fresh_q;
	logic [LEN_W-1:0]  pos_q;
	logic [BITS_W-1:0] bits_q;
	logic [IW-1:0]     nfn_q;
	logic              conflict_q;
	logic              overflow_q;
	logic              root_valid_q;
	logic [15:0]       set_cnt_q;
	logic              out_valid_q;
	logic [15:0]       out_set_q;
	logic              out_dec_q;
	logic              out_ovf_q;

	logic [EW-1:0] rdata;
	logic [EW-1:0] ent;
	logic [IW-1:0] ent_left;
	logic [IW-1:0] ent_right;
	logic          ent_mark;
	logic          has_kids;
	logic          is_final;
	logic [31:0]   bit_idx;
	logic          dir;
	logic [IW-1:0] child;
	logic [IW-1:0] new_idx;
	logic          table_full;
	logic          out_free;
	logic          pop;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;

	// A node allocated during the current walk has not been written yet and reads
	// as empty; the same holds for the root until it is first written in a set.
	assign ent       = fresh_q ? '0 : rdata;
	assign ent_left  = ent[IW-1:0];
	assign ent_right = ent[2*IW-1:IW];
	assign ent_mark  = ent[2*IW];
	assign has_kids  = (ent_left != '0) || (ent_right != '0);
	assign is_final  = (pos_q == '0);

	assign bit_idx    = 32'(pos_q) - 32'd1;
	assign dir        = (bit_idx < 32'(BITS_W)) ? bits_q[bit_idx[3:0]] : 1'b0;
	assign child      = dir ? ent_right : ent_left;
	assign new_idx    = nfn_q + 1'b1;
	assign table_full = (nfn_q == IW'(NODES - 1));

	assign out_free  = !out_valid_q || m_tready;
	assign cmd_ready = (state_q == B_IDLE) && ((cmd.op == OP_INSERT) || out_free);
	assign pop       = cmd_valid && cmd_ready;

	assign ram_raddr = (state_q == B_EVAL) ? child : '0;
	assign ram_waddr = node_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ent;
		if (state_q == B_EVAL) begin
			if (is_final) begin
				if (!ent_mark && !has_kids) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, ent_right, ent_left};
				end
			end else if (!ent_mark && (child == '0) && !table_full) begin
				ram_we    = 1'b1;
				ram_wdata = dir ? {ent_mark, new_idx, ent_left} : {ent_mark, ent_right, new_idx};
			end
		end
	end

	pctc_ram #(
		.WIDTH(EW),
		.DEPTH(NODES)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (pop && (cmd.op == OP_INSERT)) begin
			bits_q <= cmd.bits;
		end
		if (pop && (cmd.op == OP_END)) begin
			out_set_q <= set_cnt_q;
			out_dec_q <= !conflict_q;
			out_ovf_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			node_q       <= '0;
			fresh_q      <= 1'b0;
			pos_q        <= '0;
			nfn_q        <= '0;
			conflict_q   <= 1'b0;
			overflow_q   <= 1'b0;
			root_valid_q <= 1'b0;
			set_cnt_q    <= 16'd1;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && (cmd.op == OP_END)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (ram_we && (node_q == '0)) begin
				root_valid_q <= 1'b1;
			end

			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (cmd.op == OP_END) begin
							nfn_q        <= '0;
							conflict_q   <= 1'b0;
							overflow_q   <= 1'b0;
							root_valid_q <= 1'b0;
							set_cnt_q    <= set_cnt_q + 16'd1;
						end else if (!conflict_q && !overflow_q) begin
							node_q  <= '0;
							fresh_q <= !root_valid_q;
							pos_q   <= cmd.len;
							state_q <= B_EVAL;
						end
					end
				end
				B_EVAL: begin
					if (is_final) begin
						if (ent_mark || has_kids) begin
							conflict_q <= 1'b1;
						end
						state_q <= B_IDLE;
					end else if (ent_mark) begin
						conflict_q <= 1'b1;
						state_q    <= B_IDLE;
					end else if (child == '0) begin
						if (table_full) begin
							overflow_q <= 1'b1;
							state_q    <= B_IDLE;
						end else begin
							nfn_q   <= new_idx;
							node_q  <= new_idx;
							fresh_q <= 1'b1;
							pos_q   <= pos_q - 1'b1;
						end
					end else begin
						node_q  <= child;
						fresh_q <= 1'b0;
						pos_q   <= pos_q - 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_ovf_q, out_dec_q, out_set_q};

endmodule

// ===== rtl/prefix_code_trie_checker.sv =====
// Top level of the prefix code trie checker.
// Connects the front end queue to the trie walker. Depends on pctc_pkg, pctc_front,
// pctc_walk and pctc_ram.
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  tuser: opcode; tdata: code_bits, code_length
// m_*       out        m_tvalid / m_tready  tdata: set_number, decodable, overflow
//
// An insert item passes the walker in steps: start, one node table step per code bit and the
// end-node check; a conflict or overflow ends it early. Inserts after a conflict or overflow,
// and end-of-set items, are taken while idle with no walk; the end-of-set item clears the set:
// nodes are reused by allocation order and a flag tracks the root, so no clearing pass runs
// after reset or between sets. A two-entry command queue sits before the walker; items stall
// while it walks, and an end-of-set item stalls while the verdict waits in the output register.
module prefix_code_trie_checker
	import pctc_pkg::*;
#(
	parameter int NODES        = 128,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // code_bits[15:0], code_length[20:16], zero pad
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // set_number[15:0], decodable[16], overflow[17], zero pad
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	pctc_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	pctc_walk #(
		.NODES(NODES)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
